/* design/seg_pkg.sv */
// Shared types, constants and widths for the speech energy gate.
`timescale 1ns / 1ps
`default_nettype none

package seg_pkg;

    // Sample and accumulator widths
    localparam int SAMPLE_BITS      = 16;
    localparam int MAG_W            = 16;
    localparam int SQ_W             = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_W         = 50;
    localparam int COUNT_W          = 21;
    localparam int MIN_PEAK_W       = 16;
    localparam int MIN_RMS_W        = 31;

    // Split of the clip length for the two partial products
    localparam int COUNT_LO_W       = 10;
    localparam int COUNT_HI_W       = COUNT_W - COUNT_LO_W;
    localparam int PROD_LO_W        = MIN_RMS_W + COUNT_LO_W;
    localparam int PROD_HI_W        = MIN_RMS_W + COUNT_HI_W;
    localparam int PROD_W           = MIN_RMS_W + COUNT_W;

    // Clip length limit
    localparam int MAX_CLIP_SAMPLES = 1048576;
    localparam int COUNT_FIELD_MAX  = (2 ** COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        COUNT_W'((MAX_CLIP_SAMPLES < COUNT_FIELD_MAX) ? MAX_CLIP_SAMPLES : COUNT_FIELD_MAX);
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PEAK        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RMS_SQUARED = 2'd2;
    localparam logic [COUNT_W-1:0]   MIN_SAMPLES_RESET   = 21'd4800;

    // Queue between front and back
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED  = 2'd0,
        VERDICT_TOO_SHORT = 2'd1,
        VERDICT_PEAK_LOW  = 2'd2,
        VERDICT_RMS_LOW   = 2'd3
    } verdict_t;

    // Per-clip totals handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0]    peak;
        logic [ENERGY_W-1:0] energy;
        logic [COUNT_W-1:0]  count;
    } clip_totals_t;

    // Configuration registers
    typedef struct packed {
        logic [COUNT_W-1:0]    min_samples;
        logic [MIN_PEAK_W-1:0] min_peak;
        logic [MIN_RMS_W-1:0]  min_rms_squared;
    } cfg_t;

endpackage

`default_nettype wire

/* design/seg_in_if.sv */
// Audio sample channel: valid/ready with sample and last-of-clip mark.
`timescale 1ns / 1ps
`default_nettype none

interface seg_in_if import seg_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

/* design/seg_out_if.sv */
// Verdict channel: valid/ready with the per-clip verdict and totals.
`timescale 1ns / 1ps
`default_nettype none

interface seg_out_if import seg_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                acceptable;
    logic [1:0]          verdict_code;
    logic [MAG_W-1:0]    peak_level;
    logic [ENERGY_W-1:0] energy_sum;
    logic [COUNT_W-1:0]  clip_length;

    modport source (output valid, output acceptable, output verdict_code,
                    output peak_level, output energy_sum, output clip_length,
                    input ready);
    modport sink   (input valid, input acceptable, input verdict_code,
                    input peak_level, input energy_sum, input clip_length,
                    output ready);
endinterface

`default_nettype wire

/* design/seg_front.sv */
// Front end: sample magnitude, square and per-clip accumulation.
`timescale 1ns / 1ps
`default_nettype none

module seg_front import seg_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    seg_in_if.sink                 audio,
    input  wire logic [QCNT_W-1:0] q_count,
    output      logic              push,
    output      clip_totals_t      push_data
);

    localparam int PEND_W = QCNT_W + 1;

    logic [SAMPLE_BITS-1:0] raw;
    logic [MAG_W-1:0]       mag;
    logic [2*MAG_W-1:0]     sq_full;
    logic [PEND_W-1:0]      pending;
    logic                   take;

    logic                   s1_v_reg;
    logic [MAG_W-1:0]       s1_mag_reg;
    logic                   s1_last_reg;
    logic                   s2_v_reg;
    logic [MAG_W-1:0]       s2_mag_reg;
    logic [SQ_W-1:0]        s2_sq_reg;
    logic                   s2_last_reg;

    logic [MAG_W-1:0]       peak_reg, peak_next;
    logic [ENERGY_W-1:0]    energy_reg, energy_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [ENERGY_W:0]      sum_wide;

    // Hold off new samples when every queue slot may be claimed by clips in flight
    always_comb
    begin
        pending = PEND_W'(q_count) + PEND_W'(s1_v_reg & s1_last_reg)
                + PEND_W'(s2_v_reg & s2_last_reg);
    end
    assign audio.ready = (pending < PEND_W'(QUEUE_DEPTH));
    assign take        = audio.valid & audio.ready;

    // Magnitude; the most negative sample wraps to its own bit pattern
    assign raw     = audio.sample;
    assign mag     = raw[SAMPLE_BITS-1] ? MAG_W'(~raw + 1'b1) : MAG_W'(raw);
    assign sq_full = s1_mag_reg * s1_mag_reg;

    // Valid flags of stage 1 (magnitude) and stage 2 (square)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= take;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Payload of both stages
    always_ff @(posedge clk)
    begin
        s1_mag_reg  <= mag;
        s1_last_reg <= audio.last;
        s2_mag_reg  <= s1_mag_reg;
        s2_sq_reg   <= sq_full[SQ_W-1:0];
        s2_last_reg <= s1_last_reg;
    end

    // Running peak, saturating energy and saturating count
    always_comb
    begin
        sum_wide    = {1'b0, energy_reg} + (ENERGY_W + 1)'(s2_sq_reg);
        energy_next = sum_wide[ENERGY_W] ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
        peak_next   = (s2_mag_reg > peak_reg) ? s2_mag_reg : peak_reg;
        count_next  = (count_reg < COUNT_CAP) ? count_reg + 1'b1 : count_reg;
    end

    // Hand the finished clip to the queue
    assign push             = s2_v_reg & s2_last_reg;
    assign push_data.peak   = peak_next;
    assign push_data.energy = energy_next;
    assign push_data.count  = count_next;

    // Advance the totals; clear them once the clip is out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            energy_reg <= '0;
            count_reg  <= '0;
        end
        else if (s2_v_reg)
        begin
            if (s2_last_reg)
            begin
                peak_reg   <= '0;
                energy_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                peak_reg   <= peak_next;
                energy_reg <= energy_next;
                count_reg  <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

/* design/seg_queue.sv */
// Short queue of clip totals between front and back.
`timescale 1ns / 1ps
`default_nettype none

module seg_queue import seg_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire clip_totals_t      push_data,
    input  wire logic              pop,
    output      logic              head_valid,
    output      clip_totals_t      head_data,
    output      logic [QCNT_W-1:0] count
);

    clip_totals_t      slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;

    // Write the incoming clip
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/seg_back.sv */
// Back end: threshold checks on clip totals and the verdict output register.
`timescale 1ns / 1ps
`default_nettype none

module seg_back import seg_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         head_valid,
    input  wire clip_totals_t head_data,
    output      logic         pop,
    seg_out_if.source         verdict
);

    logic                   advance;
    logic                   load_b1;
    logic [PROD_W-1:0]      rms_bound;
    logic                   rms_low;
    verdict_t               code;

    logic                   b1_v_reg;
    clip_totals_t           b1_tot_reg;
    logic                   b1_short_reg;
    logic                   b1_peak_low_reg;
    logic [PROD_LO_W-1:0]   b1_prod_lo_reg;
    logic [PROD_HI_W-1:0]   b1_prod_hi_reg;

    logic                   out_v_reg;
    verdict_t               out_code_reg;
    clip_totals_t           out_tot_reg;

    // Move the back pipeline when the output slot is free or being taken
    assign advance = !out_v_reg || verdict.ready;
    assign load_b1 = advance || !b1_v_reg;
    assign pop     = load_b1 && head_valid;

    // Stage B1: length and peak checks, partial products of the rms bound
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg <= 1'b0;
        end
        else if (load_b1)
        begin
            b1_v_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b1)
        begin
            b1_tot_reg      <= head_data;
            b1_short_reg    <= (head_data.count < cfg.min_samples);
            b1_peak_low_reg <= (head_data.peak < cfg.min_peak);
            b1_prod_lo_reg  <= cfg.min_rms_squared * head_data.count[COUNT_LO_W-1:0];
            b1_prod_hi_reg  <= cfg.min_rms_squared * head_data.count[COUNT_W-1:COUNT_LO_W];
        end
    end

    // Combine partial products and pick the first failing check
    always_comb
    begin
        rms_bound = {b1_prod_hi_reg, {COUNT_LO_W{1'b0}}} + PROD_W'(b1_prod_lo_reg);
        rms_low   = (PROD_W'(b1_tot_reg.energy) < rms_bound);
        if (b1_short_reg)
        begin
            code = VERDICT_TOO_SHORT;
        end
        else if (b1_peak_low_reg)
        begin
            code = VERDICT_PEAK_LOW;
        end
        else if (rms_low)
        begin
            code = VERDICT_RMS_LOW;
        end
        else
        begin
            code = VERDICT_ACCEPTED;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_v_reg <= b1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= code;
            out_tot_reg  <= b1_tot_reg;
        end
    end

    assign verdict.valid        = out_v_reg;
    assign verdict.acceptable   = (out_code_reg == VERDICT_ACCEPTED);
    assign verdict.verdict_code = out_code_reg;
    assign verdict.peak_level   = out_tot_reg.peak;
    assign verdict.energy_sum   = out_tot_reg.energy;
    assign verdict.clip_length  = out_tot_reg.count;

endmodule

`default_nettype wire

/* design/speech_energy_gate.sv */
// Speech energy gate top level: config registers, front, queue and back.
//
// Usage:
//   audio   : valid/ready channel of signed Q1.15 samples with a last mark
//             on the final sample of each clip.
//   verdict : valid/ready channel, one transaction per clip, carrying the
//             verdict code, an accept flag, peak, energy sum and clip length.
//   cfg_*   : write port for min_samples, min_peak and min_rms_squared;
//             write only while no clip is in flight.
// Throughput: one sample per cycle; consecutive one-sample clips also run
//   at one per cycle while the receiver keeps ready high.
// Path: after the edge that takes the last sample, the clip's totals pass
//   through the second front stage, the queue, the check stage and the
//   output register, which holds the verdict.
// Stall: a held verdict stops the back end; clips pile up in the four-entry
//   queue, and audio.ready drops once every slot is spoken for by clips in
//   the queue or the front stages.
// Reset: clears the clip totals, the queue and all valid flags; thresholds
//   return to min_samples 4800, min_peak 0, min_rms_squared 0.
`timescale 1ns / 1ps
`default_nettype none

module speech_energy_gate import seg_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    seg_in_if.sink                     audio,
    seg_out_if.source                  verdict,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              q_push;
    clip_totals_t      q_push_data;
    logic              q_pop;
    logic              q_head_valid;
    clip_totals_t      q_head_data;
    logic [QCNT_W-1:0] q_count;

    // Threshold registers; writes to unused indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_samples     <= MIN_SAMPLES_RESET;
            cfg_reg.min_peak        <= '0;
            cfg_reg.min_rms_squared <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_SAMPLES:     cfg_reg.min_samples     <= cfg_data[COUNT_W-1:0];
                CFG_MIN_PEAK:        cfg_reg.min_peak        <= cfg_data[MIN_PEAK_W-1:0];
                CFG_MIN_RMS_SQUARED: cfg_reg.min_rms_squared <= cfg_data[MIN_RMS_W-1:0];
                default:             ;
            endcase
        end
    end

    seg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .audio     (audio),
        .q_count   (q_count),
        .push      (q_push),
        .push_data (q_push_data)
    );

    seg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .count      (q_count)
    );

    seg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .verdict    (verdict)
    );

`ifndef SYNTHESIS
    // Credit check in the front must keep the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("clip queue overflow");

    // Nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("pop from empty clip queue");

    // Zero energy goes with zero peak in every valid verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> ((verdict.energy_sum == '0) == (verdict.peak_level == '0)))
        else $error("energy and peak disagree");

    // Every clip holds at least one sample
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict.valid |-> (verdict.clip_length != '0))
        else $error("empty clip reported");
`endif

endmodule

`default_nettype wire
